// File: rtl/spwm_pkg.sv
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared types, constants and the quarter-wave cosine table for the
// three-phase SPWM duty generator.
// ----------------------------------------------------------------------------
package spwm_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_U   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_V   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_W   = 3'd4;

	localparam int AMP_W    = 16;
	localparam int PERIOD_W = 13;
	localparam int ANGLE_W  = 16;
	localparam int DUTY_W   = 16;
	localparam int STEP_OUT_W = 12;

	localparam logic [AMP_W-1:0]    AMP_RST    = 16'd1000;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 13'd400;
	localparam logic [ANGLE_W-1:0]  PHASE_U_RST = 16'd0;
	localparam logic [ANGLE_W-1:0]  PHASE_V_RST = 16'd21845;
	localparam logic [ANGLE_W-1:0]  PHASE_W_RST = 16'd43691;

	localparam int MAX_STEPS_DEF = 4096;

	// stream widths
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 64;

	// shared multiplier
	localparam int MUL_W  = AMP_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	// x/100 == (x * RECIP100) >> RECIP100_SH, exact for x below 91180
	localparam logic [MUL_W-1:0] RECIP100    = 17'd83887;
	localparam int               RECIP100_SH = 23;
	localparam logic [MUL_W-1:0] CEIL_BIAS   = 17'd99;

	// cosine table
	localparam int COS_POINTS  = 1024;
	localparam int COS_QUARTER = COS_POINTS / 4;
	localparam int COS_M_W     = $clog2(COS_QUARTER);
	localparam int COS_W       = 16;
	localparam logic [MUL_W-1:0] COS_MID = 17'd32768;

	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int unsigned COS_DIVS [7] = '{182, 132, 90, 56, 30, 12, 2};

	typedef logic [COS_W-1:0] cos_tab_t [COS_QUARTER];

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t    tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] r;
		logic [63:0] t;
		for (int k = 0; k < COS_QUARTER; k++) begin
			x  = (64'(k) * HALF_PI_Q30 + 64'(COS_QUARTER / 2)) / 64'(COS_QUARTER);
			x2 = (x * x) >> 30;
			r  = ONE_Q30;
			for (int j = 0; j < 7; j++) begin
				t = ((x2 * r) >> 30) / 64'(COS_DIVS[j]);
				r = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
			end
			tab[k] = COS_W'((r + (64'd1 << 14)) >> 15);
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

	typedef enum logic [1:0] {
		PH_U,
		PH_V,
		PH_W
	} phase_t;

	typedef enum logic [1:0] {
		MUL_LO,
		MUL_HI,
		MUL_DUTY
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_LO,
		S_HI,
		S_BOUND,
		S_LOOK,
		S_MUL,
		S_CLAMP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     div_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     store_lo;
		logic     store_hi;
		logic     lookup;
		logic     clamp;
		phase_t   ph;
		logic     out_load;
	} dp_cmd_t;

	localparam int DIV_STEPS = ANGLE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

// File: rtl/spwm_datapath.sv
// ----------------------------------------------------------------------------
// spwm_datapath
// Configuration registers, step counter, bit-serial angle divider, cosine
// lookup, shared multiplier, clamp and output registers.
// ----------------------------------------------------------------------------
module spwm_datapath
	import spwm_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  restart,
	input  dp_cmd_t               cmd,
	output logic [M_DATA_W-1:0]   out_data
);

	localparam int STEP_W = $clog2(MAX_STEPS);
	localparam int N_W    = $clog2(MAX_STEPS + 1);

	logic [AMP_W-1:0]    amp_q;
	logic [PERIOD_W-1:0] period_q;
	logic [ANGLE_W-1:0]  phase_u_q;
	logic [ANGLE_W-1:0]  phase_v_q;
	logic [ANGLE_W-1:0]  phase_w_q;
	logic [STEP_W-1:0]   step_q;

	logic [N_W-1:0]      n_eff;
	logic [N_W-1:0]      n_q;
	logic [STEP_W-1:0]   cur;
	logic [N_W-1:0]      cur_inc;
	logic [STEP_W-1:0]   cur_q;

	logic [N_W-1:0]      rem_q;
	logic [N_W:0]        rem_sh;
	logic                rem_ge;
	logic [ANGLE_W-1:0]  quot_q;

	logic [ANGLE_W-1:0]   phase_sel;
	logic [ANGLE_W-1:0]   angle;
	logic [1:0]           quad;
	logic [COS_M_W-1:0]   m;
	logic [COS_M_W-1:0]   tab_idx;
	logic [COS_W-1:0]     tval;
	logic [MUL_W-1:0]     cterm;
	logic [MUL_W-1:0]     cterm_q;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_q;

	logic [DUTY_W-1:0] lo_q;
	logic [DUTY_W-1:0] hi_q;
	logic [MUL_W-1:0]  raw;
	logic [DUTY_W-1:0] clamped;

	logic [DUTY_W-1:0] duty_u_q;
	logic [DUTY_W-1:0] duty_v_q;
	logic [DUTY_W-1:0] duty_w_q;
	logic [DUTY_W-1:0] out_u_q;
	logic [DUTY_W-1:0] out_v_q;
	logic [DUTY_W-1:0] out_w_q;
	logic [STEP_OUT_W-1:0] out_step_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q     <= AMP_RST;
			period_q  <= PERIOD_RST;
			phase_u_q <= PHASE_U_RST;
			phase_v_q <= PHASE_V_RST;
			phase_w_q <= PHASE_W_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AMPLITUDE: amp_q     <= cfg_data[AMP_W-1:0];
				REG_PERIOD:    period_q  <= cfg_data[PERIOD_W-1:0];
				REG_PHASE_U:   phase_u_q <= cfg_data[ANGLE_W-1:0];
				REG_PHASE_V:   phase_v_q <= cfg_data[ANGLE_W-1:0];
				REG_PHASE_W:   phase_w_q <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective period: zero acts as one, capped at MAX_STEPS
	always_comb begin
		if (period_q == '0)
			n_eff = N_W'(1);
		else if (32'(period_q) > MAX_STEPS)
			n_eff = N_W'(MAX_STEPS);
		else
			n_eff = N_W'(period_q);
	end

	assign cur     = (restart || (N_W'(step_q) >= n_eff)) ? '0 : step_q;
	assign cur_inc = N_W'(cur) + N_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= (cur_inc >= n_eff) ? '0 : STEP_W'(cur_inc);
		end
	end

	// restoring division: quot = floor(cur * 2^16 / n)
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = rem_sh >= {1'b0, n_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q  <= cur;
			n_q    <= n_eff;
			rem_q  <= N_W'(cur);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? N_W'(rem_sh - {1'b0, n_q}) : N_W'(rem_sh);
			quot_q <= {quot_q[ANGLE_W-2:0], rem_ge};
		end
	end

	// cosine lookup, held as 32768 - cos
	always_comb begin
		case (cmd.ph)
			PH_U:    phase_sel = phase_u_q;
			PH_V:    phase_sel = phase_v_q;
			PH_W:    phase_sel = phase_w_q;
			default: phase_sel = phase_u_q;
		endcase
		angle   = quot_q + phase_sel;
		quad    = angle[ANGLE_W-1 -: 2];
		m       = angle[ANGLE_W-3 -: COS_M_W];
		tab_idx = quad[0] ? COS_M_W'(-m) : m;
		tval    = (quad[0] && (m == '0)) ? '0 : COS_TAB[tab_idx];
		if (quad[1] ^ quad[0])
			cterm = COS_MID + MUL_W'(tval);
		else
			cterm = COS_MID - MUL_W'(tval);
	end

	// shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MUL_LO: begin
				mul_a = MUL_W'(amp_q);
				mul_b = RECIP100;
			end
			MUL_HI: begin
				mul_a = MUL_W'(amp_q) + CEIL_BIAS;
				mul_b = RECIP100;
			end
			MUL_DUTY: begin
				mul_a = MUL_W'(amp_q);
				mul_b = cterm_q;
			end
			default: begin
				mul_a = MUL_W'(amp_q);
				mul_b = cterm_q;
			end
		endcase
	end

	assign raw = MUL_W'(mul_q >> ANGLE_W);

	always_comb begin
		clamped = (raw > MUL_W'(hi_q)) ? hi_q : DUTY_W'(raw);
		if (clamped < lo_q)
			clamped = lo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup)
			cterm_q <= cterm;
		if (cmd.mul_en)
			mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (cmd.store_lo)
			lo_q <= DUTY_W'(mul_q >> RECIP100_SH);
		// 99*a/100 rounded down is a - ceil(a/100)
		if (cmd.store_hi)
			hi_q <= amp_q - DUTY_W'(mul_q >> RECIP100_SH);
		if (cmd.clamp) begin
			case (cmd.ph)
				PH_U:    duty_u_q <= clamped;
				PH_V:    duty_v_q <= clamped;
				PH_W:    duty_w_q <= clamped;
				default: duty_u_q <= clamped;
			endcase
		end
		if (cmd.out_load) begin
			out_u_q    <= duty_u_q;
			out_v_q    <= duty_v_q;
			out_w_q    <= duty_w_q;
			out_step_q <= STEP_OUT_W'(cur_q);
		end
	end

	assign out_data = {4'b0, out_step_q, out_w_q, out_v_q, out_u_q};

endmodule

// File: rtl/spwm_ctrl.sv
// ----------------------------------------------------------------------------
// spwm_ctrl
// Sequencer: divider steps, bound calculation, three phase passes through
// lookup, multiply and clamp, then the output hand-off.
// ----------------------------------------------------------------------------
module spwm_ctrl
	import spwm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd
);

	state_t               state_q;
	state_t               state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	phase_t               phase_q;
	phase_t               phase_nxt;
	logic                 valid_q;

	always_comb begin
		case (phase_q)
			PH_U:    phase_nxt = PH_V;
			PH_V:    phase_nxt = PH_W;
			default: phase_nxt = PH_U;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			phase_q   <= PH_U;
			valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (cmd.load)
				phase_q <= PH_U;
			else if (cmd.clamp)
				phase_q <= phase_nxt;
			if (cmd.out_load)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = MUL_DUTY;
		cmd.ph       = phase_q;
		s_tready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					state_d = S_LO;
			end
			S_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LO;
				state_d     = S_HI;
			end
			S_HI: begin
				cmd.store_lo = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_HI;
				state_d      = S_BOUND;
			end
			S_BOUND: begin
				cmd.store_hi = 1'b1;
				state_d      = S_LOOK;
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = (phase_q == PH_W) ? S_OUT : S_LOOK;
			end
			S_OUT: begin
				if (!valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign m_tvalid = valid_q;

endmodule

// File: rtl/three_phase_spwm_duty_generator_core.sv
// ----------------------------------------------------------------------------
// three_phase_spwm_duty_generator_core
// Three-phase sinusoidal PWM duty generator, one item per carrier period.
// The bit-serial angle divider and the single multiplier, shared by the bounds
// and the three phases, serve one item at a time: a new input item is taken
// only once the last item's duties are loaded into the output register.
// Reset: configuration registers return to their defaults, step index to zero.
// ----------------------------------------------------------------------------
module three_phase_spwm_duty_generator_core
	import spwm_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // restart
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // duty_u, duty_v, duty_w, step_now
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;

	spwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	spwm_datapath #(
		.MAX_STEPS (MAX_STEPS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (s_tdata[0]),
		.cmd       (cmd),
		.out_data  (m_tdata)
	);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the three-phase SPWM duty generator. Each input item is one
// carrier period. A local predictor rebuilds the quarter-wave cosine table,
// tracks the step counter and the register contents, and works out the three
// clamped duties for every accepted item. Results are checked in order,
// field by field. Stimulus opens with directed periods at the register
// extremes, then runs randomised phases with fresh settings between them,
// random gaps on both stream sides and one phase with no gaps at all.
// ----------------------------------------------------------------------------
module tb_top;
	import spwm_pkg::*;

	localparam int LIMIT_CYCLES = 800000;
	localparam int RANDOM_ITEMS = 1450;

	typedef struct packed {
		logic [DUTY_W-1:0]     duty_u;
		logic [DUTY_W-1:0]     duty_v;
		logic [DUTY_W-1:0]     duty_w;
		logic [STEP_OUT_W-1:0] step_now;
	} duty_set_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;      // restart
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;           // duty_u, duty_v, duty_w, step_now
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	int          cos_lut [COS_QUARTER+1];
	int unsigned amp_r    = AMP_RST;
	int unsigned period_r = PERIOD_RST;
	int unsigned ph_u_r   = PHASE_U_RST;
	int unsigned ph_v_r   = PHASE_V_RST;
	int unsigned ph_w_r   = PHASE_W_RST;
	int unsigned step_r   = 0;

	bit        restart_q [$];
	duty_set_t expected_duties [$];
	int        items_in_flight = 0;
	int        errors = 0;
	int        cycle_cnt = 0;
	int        s_idle_pct = 37;
	int        m_idle_pct = 37;
	bit        in_fire = 1'b0;

	three_phase_spwm_duty_generator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// quarter-wave cosine, Q1.15, from a truncated Taylor series in Q30
	initial begin
		int unsigned series_div [7];
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] r;
		logic [63:0] t;
		series_div = '{182, 132, 90, 56, 30, 12, 2};
		for (int k = 0; k <= COS_QUARTER; k++) begin
			x  = (64'(k) * 64'd1686629713 + 64'(COS_QUARTER / 2)) / 64'(COS_QUARTER);
			x2 = (x * x) >> 30;
			r  = 64'd1 << 30;
			for (int j = 0; j < 7; j++) begin
				t = ((x2 * r) >> 30) / 64'(series_div[j]);
				r = (t > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
			end
			cos_lut[k] = int'((r + (64'd1 << 14)) >> 15);
		end
		cos_lut[COS_QUARTER] = 0;
	end

	function automatic logic [DUTY_W-1:0] duty_for_angle(int unsigned angle);
		int unsigned     i;
		int unsigned     m;
		int              c;
		longint unsigned scaled;
		int unsigned     duty;
		int unsigned     lo;
		int unsigned     hi;
		i = ((angle & 32'hFFFF) * (4 * COS_QUARTER)) >> 16;
		m = i % COS_QUARTER;
		case ((i / COS_QUARTER) & 3)
			0: c = cos_lut[m];
			1: c = -cos_lut[COS_QUARTER - m];
			2: c = -cos_lut[m];
			default: c = cos_lut[COS_QUARTER - m];
		endcase
		scaled = longint'(amp_r) * longint'(32768 - c);
		duty   = int'(scaled >> 16);
		lo     = amp_r / 100;
		hi     = (99 * amp_r) / 100;
		if (duty > hi)
			duty = hi;
		if (duty < lo)
			duty = lo;
		return DUTY_W'(duty);
	endfunction

	function automatic void predict_duties(bit restart);
		int unsigned n;
		int unsigned base;
		duty_set_t   e;
		n = period_r;
		if (n == 0)
			n = 1;
		if (n > MAX_STEPS_DEF)
			n = MAX_STEPS_DEF;
		if (restart)
			step_r = 0;
		// period shortened under a running index
		if (step_r >= n)
			step_r = 0;
		base       = (step_r << 16) / n;
		e.duty_u   = duty_for_angle(base + ph_u_r);
		e.duty_v   = duty_for_angle(base + ph_v_r);
		e.duty_w   = duty_for_angle(base + ph_w_r);
		e.step_now = STEP_OUT_W'(step_r);
		expected_duties.push_back(e);
		step_r++;
		if (step_r >= n)
			step_r = 0;
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_AMPLITUDE: amp_r = data;
			REG_PERIOD:    period_r = data[PERIOD_W-1:0];
			REG_PHASE_U:   ph_u_r = data;
			REG_PHASE_V:   ph_v_r = data;
			REG_PHASE_W:   ph_w_r = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_item(bit restart);
		restart_q.push_back(restart);
		items_in_flight++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_in_flight != 0 || expected_duties.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// stream driver
	always @(negedge clk) begin
		if (!s_tvalid || in_fire) begin
			if (arst_n && restart_q.size() > 0 && $urandom_range(0, 99) >= s_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= S_DATA_W'(restart_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
	end

	// acceptance and result checking
	always @(posedge clk) begin
		duty_set_t e;
		in_fire = s_tvalid && s_tready;
		if (in_fire) begin
			predict_duties(s_tdata[0]);
			items_in_flight--;
		end
		if (m_tvalid && m_tready) begin
			if (expected_duties.size() == 0) begin
				$error("unexpected result item %h", m_tdata);
				errors++;
			end else begin
				e = expected_duties.pop_front();
				if (m_tdata[15:0] !== e.duty_u) begin
					$error("duty_u expected %0d got %0d", e.duty_u, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] !== e.duty_v) begin
					$error("duty_v expected %0d got %0d", e.duty_v, m_tdata[31:16]);
					errors++;
				end
				if (m_tdata[47:32] !== e.duty_w) begin
					$error("duty_w expected %0d got %0d", e.duty_w, m_tdata[47:32]);
					errors++;
				end
				if (m_tdata[59:48] !== e.step_now) begin
					$error("step_now expected %0d got %0d", e.step_now, m_tdata[59:48]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("three_phase_spwm_duty_generator_core test failed");
			$finish;
		end
	end

	initial begin
		int          rand_items;
		int          phase_no;
		int          n;
		int unsigned p;
		rand_items = 0;
		phase_no   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults, restart after a few steps
		push_item(0);
		push_item(0);
		push_item(0);
		push_item(1);
		push_item(0);
		wait_drained();

		// zero amplitude, zero period
		cfg_write(REG_AMPLITUDE, 16'd0);
		cfg_write(REG_PERIOD, 16'd0);
		push_item(0);
		push_item(1);
		wait_drained();

		// full amplitude, period beyond the maximum, unused indexes
		cfg_write(REG_AMPLITUDE, 16'hFFFF);
		cfg_write(REG_PERIOD, 16'hFFFF);
		cfg_write(REG_PHASE_U, 16'd0);
		cfg_write(REG_PHASE_V, 16'd16384);
		cfg_write(REG_PHASE_W, 16'd32768);
		for (int i = 1; i <= 3; i++)
			cfg_write(CFG_IDX_W'(REG_PHASE_W + i), 16'hA5A5);
		push_item(0);
		push_item(0);
		push_item(0);
		wait_drained();

		// quadrant boundaries
		cfg_write(REG_AMPLITUDE, 16'd100);
		cfg_write(REG_PERIOD, 16'd8);
		cfg_write(REG_PHASE_U, 16'hFFFF);
		cfg_write(REG_PHASE_V, 16'd49152);
		cfg_write(REG_PHASE_W, 16'd16383);
		push_item(1);
		repeat (5) push_item(0);
		wait_drained();

		// index left beyond a shortened period
		cfg_write(REG_AMPLITUDE, 16'd50000);
		cfg_write(REG_PERIOD, 16'd3);
		repeat (4) push_item(0);
		wait_drained();

		while (rand_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 7))
					0: cfg_write(REG_AMPLITUDE, 16'd0);
					1: cfg_write(REG_AMPLITUDE, 16'hFFFF);
					2: cfg_write(REG_AMPLITUDE, 16'd1);
					default: cfg_write(REG_AMPLITUDE, 16'($urandom));
				endcase
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0: p = 0;
					1: p = 1;
					2: p = MAX_STEPS_DEF;
					3: p = $urandom_range(MAX_STEPS_DEF + 1, 8191);
					4: p = $urandom_range(1, MAX_STEPS_DEF);
					default: p = $urandom_range(2, 64);
				endcase
				cfg_write(REG_PERIOD, {3'($urandom), 13'(p)});
			end
			for (int r = 0; r < 3; r++) begin
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 5))
						0: p = 0;
						1: p = 16'hFFFF;
						default: p = $urandom_range(0, 16'hFFFF);
					endcase
					cfg_write(CFG_IDX_W'(REG_PHASE_U + r), 16'(p));
				end
			end
			if ($urandom_range(0, 7) == 0)
				cfg_write(CFG_IDX_W'(REG_PHASE_W + $urandom_range(1, 3)), 16'($urandom));

			if (phase_no == 3) begin
				s_idle_pct = 0;
				m_idle_pct = 0;
				n = 150;
			end else begin
				s_idle_pct = 37;
				m_idle_pct = 37;
				n = $urandom_range(10, 120);
			end
			repeat (n)
				push_item($urandom_range(0, 15) == 0);
			rand_items += n;
			phase_no++;
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("three_phase_spwm_duty_generator_core test passed");
		else
			$display("three_phase_spwm_duty_generator_core test failed");
		$finish;
	end

endmodule
